/* src/bpe_pkg.sv */
// ----------------------------------------------------------------------------
// Bezier patch evaluator package
// Shared field widths, fixed-point constants, request codes and the store
// write bundle used by the patch evaluator and its submodules.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // Field widths of the request and result beats.
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;
  localparam int PAR_W = 16;

  // Fixed-point constants for Q1.15 parameters and the rounding step.
  localparam int                 FRAC_W    = 15;
  localparam logic [PAR_W-1:0]   ONE_Q15   = 16'h8000;
  localparam int                 PROD_W    = 50;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 50'd16384;

  typedef logic signed [VAL_W-1:0] value_t;

  // Request codes.
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_type_e;

  // One write into the control store.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    value_t           data;
  } bpe_wr_t;

  // Parameters above one saturate to one.
  function automatic logic [PAR_W-1:0] clamp_param(input logic [PAR_W-1:0] p);
    logic [PAR_W-1:0] r;
    r = (p > ONE_Q15) ? ONE_Q15 : p;
    return r;
  endfunction

endpackage

/* src/bpe_if.sv */
// ----------------------------------------------------------------------------
// Bezier patch evaluator channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------

// Request channel: control value writes and evaluate requests.
interface bpe_req_if import bpe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] point_index;
  value_t           point_value;
  logic [PAR_W-1:0] u_param;
  logic [PAR_W-1:0] v_param;

  modport source (
    output valid, req_type, point_index, point_value, u_param, v_param,
    input  ready
  );
  modport sink (
    input  valid, req_type, point_index, point_value, u_param, v_param,
    output ready
  );
endinterface

// Result channel: one patch value per evaluate request.
interface bpe_res_if import bpe_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t surface_value;

  modport source (output valid, surface_value, input ready);
  modport sink (input valid, surface_value, output ready);
endinterface

/* src/bpe_store.sv */
// ----------------------------------------------------------------------------
// Control value store
// Single-write, single-read memory with registered read data. Per-entry
// valid bits make entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module bpe_store import bpe_pkg::*; #(
  parameter int DEPTH = 36,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpe_wr_t       wr_i,
  input  logic [AW-1:0] rd_addr_i,
  output value_t        rd_data_o
);

  value_t             mem_q [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  value_t             rd_data_q;

  // Valid bits are cleared at once by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr[AW-1:0]] <= 1'b1;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    rd_data_q <= vld_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/bpe_lerp.sv */
// ----------------------------------------------------------------------------
// Interpolation unit
// Computes (1-t)*a + t*b as a + round(t*(b-a)): the product is registered,
// then rounded and added to a in the following cycle.
// ----------------------------------------------------------------------------
module bpe_lerp import bpe_pkg::*; (
  input  logic             clk_i,
  input  value_t           a_i,
  input  value_t           b_i,
  input  logic [PAR_W-1:0] t_i,
  output value_t           res_o
);

  logic signed [VAL_W:0]    diff;
  logic signed [PAR_W:0]    t_s;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;
  value_t                   a_q;
  logic signed [PROD_W-1:0] rnd;

  // Multiply stage: difference times parameter.
  assign diff   = (VAL_W+1)'(b_i) - (VAL_W+1)'(a_i);
  assign t_s    = $signed({1'b0, t_i});
  assign prod_d = PROD_W'(diff * t_s);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    a_q    <= a_i;
  end

  // Round to nearest, ties upward, then add the base value.
  assign rnd   = (prod_q + $signed(ROUND_HALF)) >>> FRAC_W;
  assign res_o = a_q + VAL_W'(rnd);

endmodule

/* src/bezier_patch_point_eval.sv */
// ----------------------------------------------------------------------------
// Bezier patch point evaluator
// Tensor-product Bezier patch of degree PATCH_DEGREE evaluated by two-pass
// de Casteljau on one shared interpolation unit.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes write beats (req_type 0) and evaluate beats (req_type 1).
//   A write stores point_value at point_index; indices past the
//   store are dropped. An evaluate returns one beat on res_o.
//   Each interpolation step passes through the shared multiply unit, with
//   S = PATCH_DEGREE+1 and P = PATCH_DEGREE*S/2 steps per reduction.
//   Each of the S rows reads S store entries and then runs P steps, then
//   the final reduction along v runs P steps and the result register is
//   loaded. The store read port and the single multiplier set the
//   evaluation time.
//   req_i.ready is low for the whole evaluation. A write beat does not
//   make the block busy. A finished result sits in an output register; the
//   next request is taken while it waits, and a later result waits until the
//   receiver has taken the previous one.
//   Reset clears the store to zero (valid bits) and empties the output.
// ----------------------------------------------------------------------------
module bezier_patch_point_eval import bpe_pkg::*; #(
  parameter int PATCH_DEGREE = 5
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bpe_req_if.sink  req_i,
  bpe_res_if.source res_o
);

  localparam int SIDE  = PATCH_DEGREE + 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(SIDE);
  localparam int NW    = $clog2(SIDE + 1);
  localparam logic [IDX_W:0] DEPTH_L = (IDX_W+1)'(DEPTH);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_COPY = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [RW-1:0]    row_q, row_d;
  logic [RW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [NW-1:0]    n_q, n_d;
  logic [NW-1:0]    k_q, k_d;
  logic             pass_q, pass_d;
  logic             rd_vld_q;
  logic [PAR_W-1:0] u_q, v_q;
  logic             out_valid_q;
  value_t           out_data_q;

  value_t           w_q [SIDE];
  value_t           w_d [SIDE];
  value_t           col_q [SIDE];
  value_t           col_d [SIDE];

  logic             accept;
  logic             eval_acc;
  logic             last_step;
  logic             step_one;
  logic             step_two;
  logic             col_push;
  logic             out_load;
  bpe_wr_t          wr;
  value_t           rd_data;
  value_t           lerp_res;
  logic [PAR_W-1:0] t_sel;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign eval_acc    = accept && (req_i.req_type == REQ_EVAL);

  // Control value writes go straight to the store.
  always_comb begin
    wr.en   = accept && (req_i.req_type == REQ_WRITE) &&
              ({1'b0, req_i.point_index} < DEPTH_L);
    wr.addr = req_i.point_index;
    wr.data = req_i.point_value;
  end

  bpe_store #(.DEPTH(DEPTH)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data)
  );

  // Shared interpolation unit on the two head entries.
  assign t_sel = pass_q ? v_q : u_q;

  bpe_lerp u_lerp (
    .clk_i (clk_i),
    .a_i   (w_q[0]),
    .b_i   (w_q[1]),
    .t_i   (t_sel),
    .res_o (lerp_res)
  );

  // Only the final step of a row reduction yields a column value.
  assign last_step = (state_q == ST_ADD) && ((k_q + NW'(2)) == n_q);
  assign step_one  = (state_q == ST_ADD) && !last_step;
  assign step_two  = last_step;
  assign col_push  = last_step && !pass_q && (n_q == NW'(2));
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || res_o.ready);

  // Sequencer next state and counters.
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    addr_d  = addr_q;
    n_d     = n_q;
    k_d     = k_q;
    pass_d  = pass_q;
    case (state_q)
      ST_IDLE: begin
        if (eval_acc) begin
          state_d = ST_LOAD;
          row_d   = '0;
          cnt_d   = '0;
          addr_d  = '0;
          pass_d  = 1'b0;
        end
      end
      ST_LOAD: begin
        addr_d = addr_q + AW'(SIDE);
        cnt_d  = cnt_q + RW'(1);
        if (cnt_q == RW'(SIDE - 1)) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_MUL;
        n_d     = NW'(SIDE);
        k_d     = '0;
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (!last_step) begin
          k_d     = k_q + NW'(1);
          state_d = ST_MUL;
        end else if (n_q != NW'(2)) begin
          n_d     = n_q - NW'(1);
          k_d     = '0;
          state_d = ST_MUL;
        end else if (pass_q) begin
          state_d = ST_OUT;
        end else if (row_q != RW'(SIDE - 1)) begin
          row_d   = row_q + RW'(1);
          addr_d  = AW'(row_q) + AW'(1);
          cnt_d   = '0;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        pass_d  = 1'b1;
        n_d     = NW'(SIDE);
        k_d     = '0;
        state_d = ST_MUL;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      row_q    <= '0;
      cnt_q    <= '0;
      addr_q   <= '0;
      n_q      <= '0;
      k_q      <= '0;
      pass_q   <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      cnt_q    <= cnt_d;
      addr_q   <= addr_d;
      n_q      <= n_d;
      k_q      <= k_d;
      pass_q   <= pass_d;
      rd_vld_q <= (state_q == ST_LOAD);
    end
  end

  // Parameters are saturated and held for the whole evaluation.
  always_ff @(posedge clk_i) begin
    if (eval_acc) begin
      u_q <= clamp_param(req_i.u_param);
      v_q <= clamp_param(req_i.v_param);
    end
  end

  // Working line: store data shifts in at the tail; each step drops the
  // head and appends its result behind the current level, and the last step
  // of a level drops two so the new level starts at the head.
  for (genvar g = 0; g < SIDE; g++) begin : g_work
    localparam logic [NW-1:0] KP1 = NW'(g + 1);
    localparam logic [NW-1:0] KP2 = NW'(g + 2);
    value_t nxt1;
    value_t nxt2;
    value_t col_nxt;

    if (g < SIDE - 1) begin : g_n1
      assign nxt1    = w_q[g+1];
      assign col_nxt = col_q[g+1];
    end else begin : g_n1_tail
      assign nxt1    = rd_data;
      assign col_nxt = lerp_res;
    end

    if (g < SIDE - 2) begin : g_n2
      assign nxt2 = w_q[g+2];
    end else begin : g_n2_tail
      assign nxt2 = lerp_res;
    end

    always_comb begin
      w_d[g] = w_q[g];
      if (rd_vld_q) begin
        w_d[g] = nxt1;
      end else if (step_one) begin
        w_d[g] = (n_q == KP1) ? lerp_res : nxt1;
      end else if (step_two) begin
        w_d[g] = (n_q == KP2) ? lerp_res : nxt2;
      end else if (state_q == ST_COPY) begin
        w_d[g] = col_q[g];
      end
      col_d[g] = col_push ? col_nxt : col_q[g];
    end

    always_ff @(posedge clk_i) begin
      w_q[g]   <= w_d[g];
      col_q[g] <= col_d[g];
    end
  end

  // Output register decouples the receiver from the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= w_q[0];
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.surface_value = out_data_q;

endmodule

/* src/bpe_chk.sv */
// ----------------------------------------------------------------------------
// Bezier patch evaluator port checker
// Watches the request and result channels of the evaluator over time.
// ----------------------------------------------------------------------------
module bpe_chk import bpe_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   req_valid_i,
  input logic   req_ready_i,
  input logic   req_type_i,
  input logic   res_valid_i,
  input logic   res_ready_i,
  input value_t res_data_i
);

  // A result beat that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_data_i))
    else $error("result value changed while stalled");

  // An accepted evaluate request makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_type_i == REQ_EVAL) |=> !req_ready_i)
    else $error("request taken during an evaluation");

  // A new result only appears at the end of an evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!req_ready_i))
    else $error("result beat without an evaluation");

endmodule

bind bezier_patch_point_eval bpe_chk u_bpe_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.req_type),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.surface_value)
);
